[rtl/bmp_pkg.sv]
`timescale 1ns / 1ps

package bmp_pkg;

    // field widths
    localparam int IN_W    = 7;
    localparam int VALUE_W = 30;
    localparam int MOD_W   = 31;

    // modulus limits and reset value
    localparam logic [MOD_W-1:0] MOD_MIN   = 31'd2;
    localparam logic [MOD_W-1:0] MOD_MAX   = 31'd1073741824;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW0,
        S_ROW,
        S_PRIME,
        S_STEP,
        S_READ,
        S_DONE
    } t_state;

endpackage

[rtl/bmp_add_mod.sv]
`timescale 1ns / 1ps

module bmp_add_mod
    import bmp_pkg::*;
(
    input  logic [VALUE_W-1:0] i_a,
    input  logic [VALUE_W-1:0] i_b,
    input  logic [MOD_W-1:0]   i_mod,
    output logic [VALUE_W-1:0] o_sum
);

    logic [MOD_W-1:0] sum;
    logic [MOD_W-1:0] red;

    // one add and one conditional subtract, operands already below the modulus
    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign red   = (sum >= i_mod) ? (sum - i_mod) : sum;
    assign o_sum = red[VALUE_W-1:0];

endmodule

[rtl/binomial_mod_pascal_top.sv]
`timescale 1ns / 1ps
// Binomial coefficient C(total, choose) modulo a configurable modulus.
// Input beats on the s_axis group carry total in tdata[6:0] and choose in
// tdata[13:7]. Each result beat on m_axis carries the value in tdata[29:0]
// and the bad_request flag in tuser. Choose above total, or total above
// MAX_TOTAL, yields value 0 with the flag set.
// The modulus is written through the cfg channel (always ready); values
// below 2 are taken as 2 and above 2^30 as 2^30. It must be written only
// while no query is in flight.
// Each query rebuilds Pascal's triangle up to row total in an internal row
// memory with one shared modular adder, writing one entry at a time. Each
// row r from 2 up writes its right end, fetches the first upper entries
// and then walks down the row; throughput is bound by the single adder and
// the single read port of the row memory.
// A refused query (total above MAX_TOTAL) skips the row build and goes
// straight to the result. s_axis_tready is high only while the sequencer
// is idle; a result in the output register does not block the next query.
// If the receiver stalls, the sequencer holds its next result until the
// output register frees. Reset (synchronous, active low) idles the
// sequencer, drops the output beat and restores the default modulus.

module binomial_mod_pascal_top
    import bmp_pkg::*;
#(
    parameter int MAX_TOTAL = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // query channel
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // total[6:0], choose[13:7], zero fill
    // result channel
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // value[29:0], zero fill
    output logic              o_m_axis_tuser,   // bad_request
    // modulus write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MOD_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_TOTAL + 1);
    localparam int CW = (AW > IN_W) ? AW : IN_W;

    t_state              r_state, n_state;
    logic [MOD_W-1:0]    r_mod;
    logic [AW-1:0]       r_total, n_total;
    logic [AW-1:0]       r_choose, n_choose;
    logic                r_bad, n_bad;
    logic                r_refused, n_refused;
    logic [AW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_col, n_col;
    logic [VALUE_W-1:0]  r_hi, n_hi;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_bad;

    // row memory controls
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [VALUE_W-1:0]  mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;
    logic [VALUE_W-1:0]  r_rd;
    logic [VALUE_W-1:0]  mem [0:MAX_TOTAL];

    logic [VALUE_W-1:0]  sum;
    logic                in_beat;
    logic                load_out;
    logic [IN_W-1:0]     in_total;
    logic [IN_W-1:0]     in_choose;

    assign in_total        = i_s_axis_tdata[IN_W-1:0];
    assign in_choose       = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // shared modular adder
    bmp_add_mod u_add (
        .i_a   (r_hi),
        .i_b   (r_rd),
        .i_mod (r_mod),
        .o_sum (sum)
    );

    // modulus register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data < MOD_MIN) begin
                r_mod <= MOD_MIN;
            end else if (i_cfg_data > MOD_MAX) begin
                r_mod <= MOD_MAX;
            end else begin
                r_mod <= i_cfg_data;
            end
        end
    end

    // row memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_total   <= n_total;
        r_choose  <= n_choose;
        r_bad     <= n_bad;
        r_refused <= n_refused;
        r_row     <= n_row;
        r_col     <= n_col;
        r_hi      <= n_hi;
    end

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_choose  = r_choose;
        n_bad     = r_bad;
        n_refused = r_refused;
        n_row     = r_row;
        n_col     = r_col;
        n_hi      = r_hi;
        mem_we    = 1'b0;
        mem_wa    = r_col;
        mem_wd    = sum;
        mem_re    = 1'b0;
        mem_ra    = r_col - AW'(1);
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_total   = AW'(in_total);
                    n_choose  = AW'(in_choose);
                    n_refused = (CW'(in_total) > CW'(MAX_TOTAL));
                    n_bad     = (CW'(in_total) > CW'(MAX_TOTAL)) || (in_choose > in_total);
                    n_row     = AW'(1);
                    n_state   = (CW'(in_total) > CW'(MAX_TOTAL)) ? S_DONE : S_ROW0;
                end
            end
            S_ROW0: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = VALUE_W'(1);
                n_state = (r_total == '0) ? S_READ : S_ROW;
            end
            S_ROW: begin
                // right end of the row, then fetch the upper neighbor of r-1
                mem_we = 1'b1;
                mem_wa = r_row;
                mem_wd = VALUE_W'(1);
                if (r_row == AW'(1)) begin
                    if (r_total == r_row) begin
                        n_state = S_READ;
                    end else begin
                        n_row = r_row + AW'(1);
                    end
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_row - AW'(1);
                    n_col   = r_row - AW'(1);
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                n_hi    = r_rd;
                mem_re  = 1'b1;
                mem_ra  = r_col - AW'(1);
                n_state = S_STEP;
            end
            S_STEP: begin
                // entry j = old[j] + old[j-1], walking down the row
                mem_we = 1'b1;
                mem_wa = r_col;
                mem_wd = sum;
                n_hi   = r_rd;
                if (r_col == AW'(1)) begin
                    if (r_total == r_row) begin
                        n_state = S_READ;
                    end else begin
                        n_row   = r_row + AW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_col - AW'(2);
                    n_col  = r_col - AW'(1);
                end
            end
            S_READ: begin
                mem_re  = !r_bad;
                mem_ra  = r_choose;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= r_bad ? '0 : r_rd;
            r_out_bad   <= r_bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(32 - VALUE_W){1'b0}}, r_out_value};
    assign o_m_axis_tuser  = r_out_bad;

`ifndef SYNTHESIS
    // read and write of the row memory never hit the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("row memory read and write at the same address");

    // a flagged result always carries a zero value
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("bad request with nonzero value");

    // effective modulus stays within its range
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mod >= MOD_MIN) && (r_mod <= MOD_MAX))
        else $error("modulus out of range");

    // inner walk stays strictly inside the current row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ((r_col >= AW'(1)) && (r_col < r_row)))
        else $error("column index outside row");

    // an accepted query leaves the idle state
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state != S_IDLE))
        else $error("query accepted but sequencer stayed idle");
`endif

endmodule
